FILE: hdl/bba_pkg.sv
package bba_pkg;

    localparam int POOL_ORDER  = 20;
    localparam int LEAF_ORDER  = 12;
    localparam int TREE_LEVELS = POOL_ORDER - LEAF_ORDER;

    localparam int ORD_W  = $clog2(POOL_ORDER + 2);
    localparam int NODE_W = TREE_LEVELS + 1;
    localparam int ROW_W  = TREE_LEVELS;
    localparam int ROWS   = (1 << TREE_LEVELS) - 1;
    localparam int DEP_W  = $clog2(TREE_LEVELS + 1);
    localparam int OFS_W  = POOL_ORDER;
    localparam int CNT_W  = POOL_ORDER + 1;

    localparam int FUNC_W     = 1;
    localparam int SIZE_W     = 21;
    localparam int ADDR_W     = 48;
    localparam int FREE_W     = 21;
    localparam int STATUS_W   = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CNT_W-1:0] POOL_BYTES = CNT_W'(1) << POOL_ORDER;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NO_FREE  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_BAD_FREE = 3'd4
    } t_status;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [0:0] {
        REG_BASE_ADDRESS = 1'b0
    } t_reg_idx;

    typedef struct packed {
        t_func              func;
        t_status            status;
        logic [ORD_W-1:0]   ord;
        logic [OFS_W-1:0]   offset;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_DESC,
        BS_CLIMB,
        BS_ASC,
        BS_RESP
    } t_bstate;

endpackage

FILE: hdl/bba_front.sv
module bba_front (
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bba_pkg::FUNC_W-1:0]    i_func,
    input  logic [bba_pkg::SIZE_W-1:0]    i_request_size,
    input  logic [bba_pkg::ADDR_W-1:0]    i_block_address,
    input  logic [bba_pkg::ADDR_W-1:0]    i_base,
    input  bba_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output bba_pkg::t_cmd                 o_cmd
);
    import bba_pkg::*;

    localparam int RAW_W = $clog2(SIZE_W + 1);

    logic [SIZE_W-1:0] size_m1;
    logic [RAW_W-1:0]  ord_raw;
    logic [ADDR_W-1:0] ofs_full;

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    // ceil(log2(size)): one past the top set bit of size-1
    always_comb begin
        size_m1 = i_request_size - SIZE_W'(1);
        ord_raw = '0;
        for (int b = 0; b < SIZE_W; b++) begin
            if (size_m1[b]) begin
                ord_raw = RAW_W'(b + 1);
            end
        end
    end

    always_comb begin
        ofs_full     = i_block_address - i_base;
        o_cmd.func   = t_func'(i_func);
        o_cmd.status = ST_OK;
        o_cmd.offset = ofs_full[OFS_W-1:0];
        if (ord_raw < RAW_W'(LEAF_ORDER)) begin
            o_cmd.ord = ORD_W'(LEAF_ORDER);
        end else begin
            o_cmd.ord = ORD_W'(ord_raw);
        end
        if (t_func'(i_func) == FN_ALLOC) begin
            if (i_request_size == '0) begin
                o_cmd.status = ST_ZERO;
            end else if (ord_raw > RAW_W'(POOL_ORDER)) begin
                o_cmd.status = ST_NO_FREE;
            end
        end else begin
            if (ofs_full[ADDR_W-1:OFS_W] != '0) begin
                o_cmd.status = ST_RANGE;
            end
        end
    end

endmodule

FILE: hdl/bba_cmd_fifo.sv
module bba_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bba_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output bba_pkg::t_cmd     o_cmd,
    output bba_pkg::t_q_stat  o_stat
);
    import bba_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + Q_PTR_W'(1);
    endfunction

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hdl/bba_back.sv
module bba_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bba_pkg::t_cmd                  i_cmd,
    input  bba_pkg::t_q_stat               i_q_stat,
    output logic                           o_pop,
    input  logic [bba_pkg::ADDR_W-1:0]     i_base,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bba_pkg::STATUS_W-1:0]   o_status,
    output logic [bba_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [bba_pkg::FREE_W-1:0]     o_free_bytes
);
    import bba_pkg::*;

    localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'((1 << TREE_LEVELS) - 1);

    // row p holds both children of node p: {right, left}; the root sits in r_root
    logic [2*ORD_W-1:0] r_tree [ROWS];
    logic [2*ORD_W-1:0] r_rdata;

    logic               mem_we, mem_re;
    logic [ROW_W-1:0]   mem_wa, mem_ra;
    logic [2*ORD_W-1:0] mem_wd;

    t_bstate            r_state, n_state;
    logic [ORD_W-1:0]   r_root, n_root;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [NODE_W-1:0]  r_node, n_node;
    logic [DEP_W-1:0]   r_left, n_left;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [ORD_W-1:0]   r_val, n_val;
    logic [ROW_W-1:0]   r_pos, n_pos;
    logic [OFS_W-1:0]   r_offset, n_offset;
    logic               r_free_op, n_free_op;
    t_status            r_res_status, n_res_status;
    logic [ROW_W-1:0]   r_clr_row, n_clr_row;
    logic [ORD_W-1:0]   r_clr_ord, n_clr_ord;
    logic [ROW_W-1:0]   r_clr_end, n_clr_end;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    logic [FREE_W-1:0]  r_out_free, n_out_free;

    logic [ORD_W-1:0]   rd_left, rd_right, cur_val, sib_val, par_val, ord_up;
    logic [NODE_W-1:0]  par_node, grand_node, leaf, child;
    logic               cur_right, go_left;

    function automatic logic [NODE_W-1:0] parent(input logic [NODE_W-1:0] n);
        return (n - NODE_W'(1)) >> 1;
    endfunction

    function automatic logic [CNT_W-1:0] pow2(input logic [ORD_W-1:0] o);
        return CNT_W'(1) << o;
    endfunction

    function automatic logic aligned(input logic [OFS_W-1:0] ofs, input logic [ORD_W-1:0] o);
        return (ofs & ((OFS_W'(1) << o) - OFS_W'(1))) == '0;
    endfunction

    assign rd_left    = r_rdata[ORD_W-1:0];
    assign rd_right   = r_rdata[2*ORD_W-1:ORD_W];
    assign par_node   = parent(r_node);
    assign grand_node = parent(par_node);
    assign cur_right  = !r_node[0];
    assign cur_val    = cur_right ? rd_right : rd_left;
    assign sib_val    = cur_right ? rd_left : rd_right;
    assign ord_up     = r_ord + ORD_W'(1);
    assign leaf       = LEAF_BASE + NODE_W'(i_cmd.offset >> LEAF_ORDER);
    assign go_left    = (rd_left >= r_ord);
    assign child      = (r_node << 1) + (go_left ? NODE_W'(1) : NODE_W'(2));

    always_comb begin
        if (r_free_op && r_val == r_ord && sib_val == r_ord) begin
            par_val = ord_up;
        end else if (r_val > sib_val) begin
            par_val = r_val;
        end else begin
            par_val = sib_val;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_root       = r_root;
        n_cnt        = r_cnt;
        n_node       = r_node;
        n_left       = r_left;
        n_ord        = r_ord;
        n_val        = r_val;
        n_pos        = r_pos;
        n_offset     = r_offset;
        n_free_op    = r_free_op;
        n_res_status = r_res_status;
        n_clr_row    = r_clr_row;
        n_clr_ord    = r_clr_ord;
        n_clr_end    = r_clr_end;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_free   = r_out_free;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_re       = 1'b0;
        mem_ra       = '0;
        o_pop        = 1'b0;

        case (r_state)
            BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_wa    = r_clr_row;
                mem_wd    = {r_clr_ord, r_clr_ord};
                n_clr_row = r_clr_row + ROW_W'(1);
                if (r_clr_row == r_clr_end) begin
                    n_clr_ord = r_clr_ord - ORD_W'(1);
                    n_clr_end = (r_clr_end << 1) + ROW_W'(2);
                end
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop     = 1'b1;
                    n_free_op = (i_cmd.func == FN_FREE);
                    n_ord     = i_cmd.ord;
                    n_offset  = i_cmd.offset;
                    n_pos     = '0;
                    n_state   = BS_RESP;
                    if (i_cmd.status != ST_OK) begin
                        n_res_status = i_cmd.status;
                    end else if (i_cmd.func == FN_ALLOC) begin
                        if (i_cmd.ord > r_root) begin
                            n_res_status = ST_NO_FREE;
                        end else if (i_cmd.ord == ORD_W'(POOL_ORDER)) begin
                            n_root       = '0;
                            n_cnt        = r_cnt - pow2(i_cmd.ord);
                            n_res_status = ST_OK;
                        end else begin
                            n_node  = '0;
                            n_left  = DEP_W'(POOL_ORDER - int'(i_cmd.ord));
                            mem_re  = 1'b1;
                            mem_ra  = '0;
                            n_state = BS_DESC;
                        end
                    end else begin
                        n_node  = leaf;
                        n_ord   = ORD_W'(LEAF_ORDER);
                        mem_re  = 1'b1;
                        mem_ra  = ROW_W'(parent(leaf));
                        n_state = BS_CLIMB;
                    end
                end
            end
            BS_DESC: begin
                n_node = child;
                n_pos  = (r_pos << 1) | ROW_W'(!go_left);
                n_left = r_left - DEP_W'(1);
                if (r_left == DEP_W'(1)) begin
                    n_val   = '0;
                    n_cnt   = r_cnt - pow2(r_ord);
                    n_state = BS_ASC;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = ROW_W'(child);
                end
            end
            BS_CLIMB: begin
                if (cur_val != '0) begin
                    if (par_node == '0) begin
                        n_state = BS_RESP;
                        if (r_root != '0 || !aligned(r_offset, ord_up)) begin
                            n_res_status = ST_BAD_FREE;
                        end else begin
                            n_root       = ord_up;
                            n_cnt        = r_cnt + pow2(ord_up);
                            n_res_status = ST_OK;
                        end
                    end else begin
                        n_node = par_node;
                        n_ord  = ord_up;
                        mem_re = 1'b1;
                        mem_ra = ROW_W'(grand_node);
                    end
                end else if (aligned(r_offset, r_ord)) begin
                    n_val   = r_ord;
                    n_cnt   = r_cnt + pow2(r_ord);
                    n_state = BS_ASC;
                end else begin
                    n_res_status = ST_BAD_FREE;
                    n_state      = BS_RESP;
                end
            end
            BS_ASC: begin
                mem_we = 1'b1;
                mem_wa = ROW_W'(par_node);
                mem_wd = cur_right ? {r_val, sib_val} : {sib_val, r_val};
                if (par_node == '0) begin
                    n_root       = par_val;
                    n_res_status = ST_OK;
                    n_state      = BS_RESP;
                end else begin
                    n_node = par_node;
                    n_val  = par_val;
                    if (r_free_op) begin
                        n_ord = ord_up;
                    end
                    mem_re = 1'b1;
                    mem_ra = ROW_W'(grand_node);
                end
            end
            BS_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_free   = FREE_W'(r_cnt);
                    if (r_res_status == ST_OK && !r_free_op) begin
                        n_out_addr = i_base + ADDR_W'(OFS_W'(r_pos) << r_ord);
                    end else begin
                        n_out_addr = '0;
                    end
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_root      <= ORD_W'(POOL_ORDER);
            r_cnt       <= POOL_BYTES;
            r_clr_row   <= '0;
            r_clr_ord   <= ORD_W'(POOL_ORDER - 1);
            r_clr_end   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root      <= n_root;
            r_cnt       <= n_cnt;
            r_clr_row   <= n_clr_row;
            r_clr_ord   <= n_clr_ord;
            r_clr_end   <= n_clr_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_left       <= n_left;
        r_ord        <= n_ord;
        r_val        <= n_val;
        r_pos        <= n_pos;
        r_offset     <= n_offset;
        r_free_op    <= n_free_op;
        r_res_status <= n_res_status;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_free   <= n_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_tree[mem_ra];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_addr;
    assign o_free_bytes      = r_out_free;

endmodule

FILE: hdl/buddy_block_allocator.sv
// Buddy allocator over a 1 MiB pool (2^20 bytes, 4 KiB minimum block) starting at base_address.
// Requests enter through a two-beat command queue, so a new beat is taken while the engine
// works and a result waits. The engine walks a 255-row order tree memory, one row per cycle:
// an allocate goes down then up the tree, a free climbs from its leaf and then back up, and an
// error goes straight to the result. After reset the engine clears the tree before it starts
// on the first request; requests and register writes are taken meanwhile. base_address sits
// at byte address 0 of the APB port (64-bit data, low 48 used).
module buddy_block_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bba_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bba_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bba_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bba_pkg::FUNC_W-1:0]        i_func,
    input  logic [bba_pkg::SIZE_W-1:0]        i_request_size,
    input  logic [bba_pkg::ADDR_W-1:0]        i_block_address,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bba_pkg::STATUS_W-1:0]      o_status,
    output logic [bba_pkg::ADDR_W-1:0]        o_granted_address,
    output logic [bba_pkg::FREE_W-1:0]        o_free_bytes
);
    import bba_pkg::*;

    logic [ADDR_W-1:0] r_base_address;
    t_reg_idx          reg_idx;
    logic              cfg_wr;
    t_q_stat           q_stat;
    t_cmd              push_cmd, head_cmd;
    logic              push, pop;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == REG_BASE_ADDRESS) ? CFG_DATA_W'(r_base_address) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address <= '0;
        end else if (cfg_wr && reg_idx == REG_BASE_ADDRESS) begin
            r_base_address <= pwdata[ADDR_W-1:0];
        end
    end

    bba_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .i_base          (r_base_address),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    bba_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    bba_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (head_cmd),
        .i_q_stat          (q_stat),
        .o_pop             (pop),
        .i_base            (r_base_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_free_bytes      (o_free_bytes)
    );

    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_granted_address == '0)
        else $error("granted address set on a failed request");

    a_free_within_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> FREE_W'(o_free_bytes) <= FREE_W'(POOL_BYTES))
        else $error("free byte count above pool size");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("command queue both full and empty");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("engine took a command from an empty queue");

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int NODES       = (2 << TREE_LEVELS) - 1;
    localparam int LEAF_FIRST  = (1 << TREE_LEVELS) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        t_status             status;
        logic [ADDR_W-1:0]   addr;
        logic [FREE_W-1:0]   free_b;
    } t_grant;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [FUNC_W-1:0]       i_func;
    logic [SIZE_W-1:0]       i_request_size;
    logic [ADDR_W-1:0]       i_block_address;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [STATUS_W-1:0]     o_status;
    logic [ADDR_W-1:0]       o_granted_address;
    logic [FREE_W-1:0]       o_free_bytes;

    buddy_block_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_request_size    (i_request_size),
        .i_block_address   (i_block_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_free_bytes      (o_free_bytes)
    );

    // allocator state mirror
    logic [ORD_W-1:0]        order_tree [NODES];
    logic [FREE_W-1:0]       pool_free;
    logic [ADDR_W-1:0]       base_reg;
    logic [OFS_W-1:0]        live_offsets [$];
    t_grant                  pending [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_epoch  = 0;
    int mismatches  = 0;
    int n_requests  = 0;
    int n_grants    = 0;
    int n_frees     = 0;
    int n_bases     = 0;
    int n_status [5];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] pick_addr48();
        return {16'($urandom_range(0, 65535)), 32'($urandom())};
    endfunction

    function automatic void note_mismatch(string what, longint unsigned want,
                                          longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at %0t: %s expected 0x%0h got 0x%0h",
                     mismatches, $realtime, what, want, got);
    endfunction

    function automatic void reset_allocator_state();
        int unsigned level_end;
        int unsigned ord;
        level_end = 1;
        ord = POOL_ORDER;
        for (int n = 0; n < NODES; n++) begin
            if (n == level_end) begin
                ord--;
                level_end = 2 * level_end + 1;
            end
            order_tree[n] = ORD_W'(ord);
        end
        pool_free = FREE_W'(64'd1 << POOL_ORDER);
        base_reg = '0;
        live_offsets.delete();
    endfunction

    function automatic t_grant predict_request(t_func fn, logic [SIZE_W-1:0] req_size,
                                               logic [ADDR_W-1:0] blk_addr);
        t_grant             res;
        int unsigned        ord;
        int unsigned        depth;
        int unsigned        idx;
        int unsigned        kid;
        longint unsigned    ofs;
        logic [ADDR_W-1:0]  ofs48;
        logic [ORD_W-1:0]   lo;
        logic [ORD_W-1:0]   ro;
        res.status = ST_OK;
        res.addr = '0;
        if (fn == FN_ALLOC) begin
            if (req_size == 0) begin
                res.status = ST_ZERO;
            end else begin
                ord = 0;
                while (ord < 40 && (64'd1 << ord) < req_size)
                    ord++;
                if (ord < LEAF_ORDER)
                    ord = LEAF_ORDER;
                if (ord > order_tree[0]) begin
                    res.status = ST_NO_FREE;
                end else begin
                    depth = POOL_ORDER - ord;
                    idx = 0;
                    for (int d = 0; d < depth; d++) begin
                        kid = 2 * idx + 1;
                        idx = (order_tree[kid] >= ord) ? kid : kid + 1;
                    end
                    ofs = ((64'(idx) + 1) - (64'd1 << depth)) << ord;
                    order_tree[idx] = '0;
                    pool_free = pool_free - FREE_W'(64'd1 << ord);
                    live_offsets.push_back(OFS_W'(ofs));
                    while (idx != 0) begin
                        idx = (idx - 1) >> 1;
                        lo = order_tree[2 * idx + 1];
                        ro = order_tree[2 * idx + 2];
                        order_tree[idx] = (lo > ro) ? lo : ro;
                    end
                    res.addr = base_reg + ADDR_W'(ofs);
                    n_grants++;
                end
            end
        end else begin
            ofs48 = blk_addr - base_reg;
            ofs = 64'(ofs48);
            if (ofs >= (64'd1 << POOL_ORDER)) begin
                res.status = ST_RANGE;
            end else begin
                idx = int'(ofs >> LEAF_ORDER) + LEAF_FIRST;
                ord = LEAF_ORDER;
                while (idx != 0 && order_tree[idx] != 0) begin
                    ord++;
                    idx = (idx - 1) >> 1;
                end
                if (order_tree[idx] != 0 ||
                    ofs != ((64'(idx) + 1) << ord) - (64'd1 << POOL_ORDER)) begin
                    res.status = ST_BAD_FREE;
                end else begin
                    order_tree[idx] = ORD_W'(ord);
                    pool_free = pool_free + FREE_W'(64'd1 << ord);
                    for (int k = 0; k < live_offsets.size(); k++)
                        if (live_offsets[k] == OFS_W'(ofs)) begin
                            live_offsets.delete(k);
                            break;
                        end
                    // merge buddies on the way up
                    while (idx != 0) begin
                        idx = (idx - 1) >> 1;
                        lo = order_tree[2 * idx + 1];
                        ro = order_tree[2 * idx + 2];
                        if (lo == ord && ro == ord)
                            order_tree[idx] = ORD_W'(ord + 1);
                        else
                            order_tree[idx] = (lo > ro) ? lo : ro;
                        ord++;
                    end
                    n_frees++;
                end
            end
        end
        res.free_b = pool_free;
        n_status[res.status]++;
        return res;
    endfunction

    // request side: caller sits on a rising edge
    task automatic send_request(t_func fn, logic [SIZE_W-1:0] sz,
                                logic [ADDR_W-1:0] addr, output t_grant res);
        int idle;
        idle = 0;
        while (idle < 20 && $urandom_range(99) < tx_idle_pct)
            idle++;
        if (idle != 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= fn;
        i_request_size  <= sz;
        i_block_address <= addr;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = predict_request(fn, sz, addr);
        pending.push_back(res);
        n_requests++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_base(logic [ADDR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(8 * int'(REG_BASE_ADDRESS));
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        base_reg = value;
        n_bases++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[ADDR_W-1:0] !== value)
            note_mismatch("base_address readback", value, prdata[ADDR_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending.size() == 0) begin
                note_mismatch("result beat with nothing pending", 0, o_status);
            end else begin
                want = pending.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", want.status, o_status);
                if (o_granted_address !== want.addr)
                    note_mismatch("granted_address", want.addr, o_granted_address);
                if (o_free_bytes !== want.free_b)
                    note_mismatch("free_bytes", want.free_b, o_free_bytes);
            end
        end
    end

    // result side ready, with an occasional long hold-off
    initial begin
        int hold_seen;
        hold_seen = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_epoch != hold_seen) begin
                hold_seen = hold_epoch;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic test_directed_cases();
        t_grant r_one;
        t_grant r_leaf;
        t_grant r_two;
        t_grant r_pool;
        t_grant r_half;
        t_grant junk;
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        write_base({ADDR_W{1'b1}});
        send_request(FN_ALLOC, '0, '0, junk);
        send_request(FN_ALLOC, 21'd1, '0, r_one);
        send_request(FN_ALLOC, 21'd4096, '0, r_leaf);
        send_request(FN_ALLOC, 21'd4097, '0, r_two);
        send_request(FN_ALLOC, {SIZE_W{1'b1}}, {ADDR_W{1'b1}}, junk);
        send_request(FN_ALLOC, 21'h10_0000, '0, junk);
        send_request(FN_FREE, '0, base_reg + 48'h10_0000, junk);
        send_request(FN_FREE, '0, base_reg - 48'd1, junk);
        send_request(FN_FREE, '0, r_two.addr + 48'd4096, junk);
        send_request(FN_FREE, {SIZE_W{1'b1}}, r_one.addr, junk);
        send_request(FN_FREE, '0, r_one.addr, junk);
        send_request(FN_FREE, '0, r_leaf.addr, junk);
        send_request(FN_FREE, '0, r_two.addr, junk);
        send_request(FN_ALLOC, 21'h10_0000, '0, r_pool);
        send_request(FN_ALLOC, 21'd1, '0, junk);
        send_request(FN_FREE, '0, r_pool.addr + 48'd4096, junk);
        send_request(FN_FREE, '0, r_pool.addr, junk);
        send_request(FN_ALLOC, 21'h8_0000, '0, r_half);
        send_request(FN_ALLOC, 21'h8_0001, '0, junk);
        send_request(FN_FREE, '0, r_half.addr, junk);
        wait_drained();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int count,
                                       logic [ADDR_W-1:0] new_base);
        t_grant             junk;
        int                 sel;
        int                 alloc_pct;
        int unsigned        pick;
        logic [SIZE_W-1:0]  sz;
        logic [ADDR_W-1:0]  addr;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_base(new_base);
        repeat (count) begin
            alloc_pct = (live_offsets.size() > 24) ? 30 : 60;
            sel = $urandom_range(99);
            sz = SIZE_W'($urandom());
            addr = pick_addr48();
            if (sel < alloc_pct) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    sz = '0;
                else if (pick < 70)
                    sz = SIZE_W'($urandom_range(1, 16384));
                else if (pick < 90)
                    sz = SIZE_W'($urandom_range(16385, 262144));
                else if (pick < 97)
                    sz = SIZE_W'($urandom_range(262145, 1048576));
                else
                    sz = SIZE_W'($urandom_range(1048577, 2097151));
                send_request(FN_ALLOC, sz, addr, junk);
            end else if (sel < 92 && live_offsets.size() != 0) begin
                pick = $urandom_range(live_offsets.size() - 1);
                addr = base_reg + ADDR_W'(live_offsets[pick]);
                if ($urandom_range(99) < 12)
                    addr = addr + ADDR_W'($urandom_range(1, 64) * 4096);
                send_request(FN_FREE, sz, addr, junk);
            end else begin
                if ($urandom_range(1) == 0)
                    addr = base_reg + ADDR_W'($urandom_range(0, 1048575));
                send_request(FN_FREE, sz, addr, junk);
            end
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        t_grant junk;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_base(48'h8000_0000_0000);
        hold_epoch++;
        for (int k = 0; k < 24; k++) begin
            if (k % 3 == 2 && live_offsets.size() != 0)
                send_request(FN_FREE, '0, base_reg + ADDR_W'(live_offsets[0]), junk);
            else
                send_request(FN_ALLOC, SIZE_W'($urandom_range(1, 8192)), '0, junk);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_func          <= FN_ALLOC;
        i_request_size  <= '0;
        i_block_address <= '0;
        reset_allocator_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(29, 75, 170, '0);
        test_random_traffic(75, 29, 170, pick_addr48());
        test_random_traffic(0, 0, 170, pick_addr48());
        test_output_backpressure();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d requests over %0d pool bases: %0d grants, %0d frees",
                 n_requests, n_bases, n_grants, n_frees);
        $display("errors seen: %0d zero size, %0d no room, %0d out of pool, %0d bad free",
                 n_status[ST_ZERO], n_status[ST_NO_FREE], n_status[ST_RANGE],
                 n_status[ST_BAD_FREE]);
        if (mismatches == 0 && pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
